// ===== sv/rgbhs_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbhs_pkg: shared constants and types for the RGB to hue/saturation block
// Widths, the CORDIC angle table and the stage payload structures.
// ----------------------------------------------------------------------------
package rgbhs_pkg;

    localparam int CHAN_W       = 16;
    localparam int HUE_W        = 15;
    localparam int SAT_W        = 16;
    localparam int HUE_FRAC     = 6;
    localparam int CORDIC_STEPS = 20;
    localparam int QUO_W        = SAT_W + 1;
    localparam int SUM_W        = CHAN_W + 2;
    localparam int DIV_W        = SUM_W + SAT_W;
    localparam int XIN_W        = CHAN_W + 3;
    localparam int PROD_W       = CHAN_W + 21;
    localparam int XW           = 42;
    localparam int ZW           = 26;
    localparam int NSTAGE       = CORDIC_STEPS + 3;

    localparam logic [20:0] SQRT3_Q20 = 21'd1816187;

    // Angles in units of 2^-16 degree.
    localparam int DEG90      = 90 * 65536;
    localparam int DEG180     = 180 * 65536;
    localparam int DEG360     = 360 * 65536;
    localparam int HUE_ROUND  = 1 << (15 - HUE_FRAC);
    localparam int HUE_SHIFT  = 16 - HUE_FRAC;
    localparam int HUE_WRAP   = 360 << HUE_FRAC;

    // atan(2^-i) in units of 2^-16 degree, rounded.
    localparam logic [22:0] ATAN_Q16 [CORDIC_STEPS] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379,
        23'd117304,  23'd58666,   23'd29335,  23'd14668,  23'd7334,
        23'd3667,    23'd1833,    23'd917,    23'd458,    23'd229,
        23'd115,     23'd57,      23'd29,     23'd14,     23'd7
    };

    typedef struct packed {
        logic [SUM_W-1:0]        sum;
        logic [SUM_W-1:0]        num;
        logic signed [XIN_W-1:0] x;
        logic [CHAN_W-1:0]       ad;
        logic                    dneg;
        logic                    gray;
        logic                    black;
    } t_front;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [SUM_W-1:0]     rem;
        logic [SUM_W-1:0]     sum;
        logic [QUO_W-1:0]     low;
        logic [QUO_W-1:0]     quo;
        logic                 dneg;
        logic                 gray;
        logic                 black;
    } t_work;

endpackage

// ===== sv/rgbhs_if.sv =====
// ----------------------------------------------------------------------------
// rgbhs channel interfaces
// Pixel input channel and hue/saturation result channel, valid/ready.
// ----------------------------------------------------------------------------
interface rgbhs_pix_if;
    logic                          valid;
    logic                          ready;
    logic [rgbhs_pkg::CHAN_W-1:0]  red;
    logic [rgbhs_pkg::CHAN_W-1:0]  green;
    logic [rgbhs_pkg::CHAN_W-1:0]  blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhs_hs_if;
    logic                         valid;
    logic                         ready;
    logic [rgbhs_pkg::HUE_W-1:0]  hue;
    logic [rgbhs_pkg::SAT_W-1:0]  saturation;
    logic                         black_flag;

    modport source (output valid, output hue, output saturation, output black_flag,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input black_flag,
                    output ready);
endinterface

// ===== sv/rgbhs_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// rgbhs_cordic_stage: one registered pipeline stage
// One vectoring CORDIC rotation; steps below QUO_W also give one restoring-division quotient bit.
// ----------------------------------------------------------------------------
module rgbhs_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_valid,
    input  rgbhs_pkg::t_work   i_data,
    output logic               o_valid,
    output rgbhs_pkg::t_work   o_data
);

    logic                                r_valid;
    rgbhs_pkg::t_work                    r_data;
    rgbhs_pkg::t_work                    n_data;
    logic signed [rgbhs_pkg::XW-1:0]     xs;
    logic signed [rgbhs_pkg::XW-1:0]     ys;
    logic [rgbhs_pkg::SUM_W:0]           trial;
    logic [rgbhs_pkg::SUM_W:0]           divisor;
    logic                                qbit;

    assign xs      = i_data.x >>> STEP;
    assign ys      = i_data.y >>> STEP;
    assign trial   = {i_data.rem, i_data.low[rgbhs_pkg::QUO_W-1]};
    assign divisor = {1'b0, i_data.sum};
    assign qbit    = (trial >= divisor);

    always_comb begin
        n_data = i_data;
        // Drive the vector toward the positive x axis.
        if (i_data.y > 0) begin
            n_data.x = i_data.x + ys;
            n_data.y = i_data.y - xs;
            n_data.z = i_data.z + rgbhs_pkg::ZW'(rgbhs_pkg::ATAN_Q16[STEP]);
        end else begin
            n_data.x = i_data.x - ys;
            n_data.y = i_data.y + xs;
            n_data.z = i_data.z - rgbhs_pkg::ZW'(rgbhs_pkg::ATAN_Q16[STEP]);
        end
        if (STEP < rgbhs_pkg::QUO_W) begin
            if (qbit) begin
                n_data.rem = rgbhs_pkg::SUM_W'(trial - divisor);
            end else begin
                n_data.rem = trial[rgbhs_pkg::SUM_W-1:0];
            end
            n_data.quo = {i_data.quo[rgbhs_pkg::QUO_W-2:0], qbit};
            n_data.low = {i_data.low[rgbhs_pkg::QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== sv/rgb_to_hue_saturation.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hue_saturation: RGB pixel to HSI hue and saturation
// Deep pipeline with a CORDIC angle unit and a bit-serial saturation divider.
// ----------------------------------------------------------------------------
// Usage. Pixels enter on i_pix (red, green, blue, unsigned Q0.16) and results
// leave on o_hs (hue in 1/64 degree, saturation in Q0.16, black flag). Both
// channels use valid/ready; an item moves when valid and ready are high at a
// rising clock edge.
// From input accept to output valid a pixel passes one stage for the
// channel min/sum/difference terms, one for the sqrt(3) multiply and CORDIC
// pre-rotation, twenty CORDIC stages (the first seventeen also produce one
// saturation quotient bit each), and one stage for clamping, mirroring and
// rounding into the output register.
// Throughput is one pixel per clock unless o_hs stalls; the twenty-stage
// CORDIC chain sets the latency, and every stage holds a valid bit of its own.
// When the receiver stalls, the output register holds its item and each stage
// keeps accepting as long as a bubble sits downstream of it, so input ready
// drops only once every stage is full. Nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits; data registers are
// not reset. The block carries no state between pixels.
// ----------------------------------------------------------------------------
module rgb_to_hue_saturation (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rgbhs_pix_if.sink     i_pix,
    rgbhs_hs_if.source    o_hs
);

    localparam int NS = rgbhs_pkg::NSTAGE;
    localparam int CS = rgbhs_pkg::CORDIC_STEPS;

    logic [NS-1:0]       v;
    logic [NS-1:0]       rdy;

    // Stage 0: front-end arithmetic on the raw channels.
    rgbhs_pkg::t_front                         n_front;
    rgbhs_pkg::t_front                         r_front;
    logic                                      r_va;
    logic [rgbhs_pkg::CHAN_W-1:0]              mn;
    logic signed [rgbhs_pkg::XIN_W-1:0]        rr;
    logic signed [rgbhs_pkg::XIN_W-1:0]        gg;
    logic signed [rgbhs_pkg::XIN_W-1:0]        bb;

    assign rr = signed'({3'b000, i_pix.red});
    assign gg = signed'({3'b000, i_pix.green});
    assign bb = signed'({3'b000, i_pix.blue});

    always_comb begin
        mn = i_pix.red;
        if (i_pix.green < mn) begin
            mn = i_pix.green;
        end
        if (i_pix.blue < mn) begin
            mn = i_pix.blue;
        end
        n_front.sum = rgbhs_pkg::SUM_W'(i_pix.red) + rgbhs_pkg::SUM_W'(i_pix.green)
                    + rgbhs_pkg::SUM_W'(i_pix.blue);
        n_front.num = n_front.sum - (rgbhs_pkg::SUM_W'(mn) + (rgbhs_pkg::SUM_W'(mn) << 1));
        n_front.x    = (rr <<< 1) - gg - bb;
        n_front.dneg = (i_pix.green < i_pix.blue);
        if (n_front.dneg) begin
            n_front.ad = i_pix.blue - i_pix.green;
        end else begin
            n_front.ad = i_pix.green - i_pix.blue;
        end
        n_front.gray  = (i_pix.red == i_pix.green) && (i_pix.green == i_pix.blue);
        n_front.black = (i_pix.red == '0) && (i_pix.green == '0) && (i_pix.blue == '0);
    end

    // Stage 1: sqrt(3)*|g-b|, pre-rotation into the right half plane, and the
    // rounded saturation dividend (num * 2^16 + sum/2).
    rgbhs_pkg::t_work                          n_work;
    rgbhs_pkg::t_work                          w [CS+1];
    logic [rgbhs_pkg::PROD_W-1:0]              prod;
    logic signed [rgbhs_pkg::XW-1:0]           xw;
    logic [rgbhs_pkg::DIV_W-1:0]               dividend;

    assign prod     = rgbhs_pkg::PROD_W'(r_front.ad) * rgbhs_pkg::PROD_W'(rgbhs_pkg::SQRT3_Q20);
    assign xw       = rgbhs_pkg::XW'(r_front.x) <<< 20;
    assign dividend = {r_front.num, {rgbhs_pkg::SAT_W{1'b0}}}
                    + rgbhs_pkg::DIV_W'(r_front.sum >> 1);

    always_comb begin
        if (r_front.x < 0) begin
            // Turn by -90 degrees so the CORDIC starts in the right half plane.
            n_work.x = rgbhs_pkg::XW'(prod);
            n_work.y = -xw;
            n_work.z = rgbhs_pkg::ZW'(rgbhs_pkg::DEG90);
        end else begin
            n_work.x = xw;
            n_work.y = rgbhs_pkg::XW'(prod);
            n_work.z = '0;
        end
        n_work.rem   = rgbhs_pkg::SUM_W'(dividend[rgbhs_pkg::DIV_W-1:rgbhs_pkg::QUO_W]);
        n_work.low   = dividend[rgbhs_pkg::QUO_W-1:0];
        n_work.quo   = '0;
        n_work.sum   = r_front.sum;
        n_work.dneg  = r_front.dneg;
        n_work.gray  = r_front.gray;
        n_work.black = r_front.black;
    end

    rgbhs_pkg::t_work r_work_b;
    logic             r_vb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (rdy[0]) begin
                r_va <= i_pix.valid;
            end
            if (rdy[1]) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_front <= n_front;
        end
        if (rdy[1]) begin
            r_work_b <= n_work;
        end
    end

    assign v[0] = r_va;
    assign v[1] = r_vb;
    assign w[0] = r_work_b;

    // Stages 2 to 21: CORDIC rotations with the divider riding along.
    for (genvar i = 0; i < CS; i++) begin : g_cordic
        rgbhs_cordic_stage #(.STEP(i)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (rdy[i+2]),
            .i_valid (v[i+1]),
            .i_data  (w[i]),
            .o_valid (v[i+2]),
            .o_data  (w[i+1])
        );
    end

    // A stage may load when it is empty or when the stage after it moves.
    for (genvar k = 0; k < NS - 1; k++) begin : g_ready
        assign rdy[k] = ~v[k] | rdy[k+1];
    end
    assign rdy[NS-1] = ~v[NS-1] | o_hs.ready;
    assign i_pix.ready = rdy[0];

    // Final stage: clamp theta, gray, mirror for g < b, round, wrap, black.
    logic [rgbhs_pkg::ZW-1:0]      theta;
    logic [rgbhs_pkg::ZW-1:0]      fine;
    logic [rgbhs_pkg::ZW-1:0]      fine_r;
    logic [rgbhs_pkg::ZW-1:0]      hue_full;
    logic [rgbhs_pkg::HUE_W-1:0]   n_hue;
    logic [rgbhs_pkg::SAT_W-1:0]   n_sat;
    logic [rgbhs_pkg::HUE_W-1:0]   r_hue;
    logic [rgbhs_pkg::SAT_W-1:0]   r_sat;
    logic                          r_black;
    logic                          r_vo;

    always_comb begin
        if (w[CS].z < 0) begin
            theta = '0;
        end else if (w[CS].z > rgbhs_pkg::DEG180) begin
            theta = rgbhs_pkg::ZW'(rgbhs_pkg::DEG180);
        end else begin
            theta = w[CS].z;
        end
        if (w[CS].gray) begin
            fine = rgbhs_pkg::ZW'(rgbhs_pkg::DEG90);
        end else if (w[CS].dneg) begin
            fine = rgbhs_pkg::ZW'(rgbhs_pkg::DEG360) - theta;
        end else begin
            fine = theta;
        end
        fine_r   = fine + rgbhs_pkg::ZW'(rgbhs_pkg::HUE_ROUND);
        hue_full = fine_r >> rgbhs_pkg::HUE_SHIFT;
        if (hue_full >= rgbhs_pkg::ZW'(rgbhs_pkg::HUE_WRAP)) begin
            n_hue = '0;
        end else begin
            n_hue = hue_full[rgbhs_pkg::HUE_W-1:0];
        end
        // A rounded quotient of exactly one saturates to the top code.
        if (w[CS].quo[rgbhs_pkg::QUO_W-1]) begin
            n_sat = '1;
        end else begin
            n_sat = w[CS].quo[rgbhs_pkg::SAT_W-1:0];
        end
        if (w[CS].black) begin
            n_hue = '0;
            n_sat = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (rdy[NS-1]) begin
            r_vo <= v[NS-2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[NS-1]) begin
            r_hue   <= n_hue;
            r_sat   <= n_sat;
            r_black <= w[CS].black;
        end
    end

    assign v[NS-1]         = r_vo;
    assign o_hs.valid      = r_vo;
    assign o_hs.hue        = r_hue;
    assign o_hs.saturation = r_sat;
    assign o_hs.black_flag = r_black;

endmodule

// ===== sv/rgbhs_checker.sv =====
// ----------------------------------------------------------------------------
// rgbhs_checker: port-level assertions for rgb_to_hue_saturation
// Watches the result channel for range, black handling, reset and stalls.
// ----------------------------------------------------------------------------
module rgbhs_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [rgbhs_pkg::HUE_W-1:0]   i_hue,
    input  logic [rgbhs_pkg::SAT_W-1:0]   i_sat,
    input  logic                          i_black
);

    // The wrap at 360 degrees must keep every hue below a full turn.
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_hue < rgbhs_pkg::HUE_W'(rgbhs_pkg::HUE_WRAP)))
        else $error("hue reached a full turn");

    // A black pixel forces both hue and saturation to zero.
    a_black_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_black) |-> (i_hue == '0 && i_sat == '0))
        else $error("black item with nonzero hue or saturation");

    // The pipeline is empty in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds until it is taken.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_hue) && $stable(i_sat) && $stable(i_black)))
        else $error("stalled result changed");

endmodule

bind rgb_to_hue_saturation rgbhs_checker u_rgbhs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_hs.valid),
    .i_out_ready (o_hs.ready),
    .i_hue       (o_hs.hue),
    .i_sat       (o_hs.saturation),
    .i_black     (o_hs.black_flag)
);
